### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the queue top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GMPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define GMPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### hdl/gmpq_pkg.sv
// ----------------------------------------------------------------------------
// gmpq_pkg
// types and codes shared by the grouped min priority queue
// ----------------------------------------------------------------------------
package gmpq_pkg;

	// cells per partial or-reduction of the removed id
	localparam int CHUNK = 16;

	localparam logic ACT_ADD    = 1'b0;
	localparam logic ACT_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_ABSENT     = 2'd1,
		STAT_STORE_FULL = 2'd2,
		STAT_GTAB_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_APPLY,
		S_FIN
	} state_t;

	// priority in the upper half so that a plain compare orders by priority, then id
	typedef struct packed {
		logic [31:0] prio;
		logic [31:0] id;
	} key_t;

	typedef struct packed {
		logic ins;
		logic rem;
		key_t key;
	} ent_ctrl_t;

	typedef struct packed {
		logic create;
		logic inc;
		logic dec;
	} grp_op_t;

endpackage

### hdl/gmpq_req_if.sv
// ----------------------------------------------------------------------------
// gmpq_req_if
// request channel: add or remove with group tag, id and priority
// ----------------------------------------------------------------------------
interface gmpq_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] group_tag;
	logic        [31:0] item_id;
	logic        [31:0] priority_req;

	modport source (output valid, action, group_tag, item_id, priority_req, input ready);
	modport sink (input valid, action, group_tag, item_id, priority_req, output ready);
endinterface

### hdl/gmpq_rsp_if.sv
// ----------------------------------------------------------------------------
// gmpq_rsp_if
// response channel: found flag, removed id and status
// ----------------------------------------------------------------------------
interface gmpq_rsp_if;
	logic        valid;
	logic        ready;
	logic        found;
	logic [31:0] removed_id;
	logic [1:0]  status;

	modport source (output valid, found, removed_id, status, input ready);
	modport sink (input valid, found, removed_id, status, output ready);
endinterface

### hdl/gmpq_entry_cell.sv
// ----------------------------------------------------------------------------
// gmpq_entry_cell
// one slot of the sorted entry chain, ordered by {group, priority, id};
// shifts right on insert and left on remove
// ----------------------------------------------------------------------------
module gmpq_entry_cell import gmpq_pkg::*; #(
	parameter int GIW = 6
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ent_ctrl_t      ctrl,
	input  logic [GIW-1:0] grp,
	input  logic           left_valid,
	input  logic [GIW-1:0] left_grp,
	input  key_t           left_key,
	input  logic           left_gt,
	input  logic           right_valid,
	input  logic [GIW-1:0] right_grp,
	input  key_t           right_key,
	output logic           valid,
	output logic [GIW-1:0] grp_out,
	output key_t           key,
	output logic           gt,
	output logic           head
);

	logic           valid_q;
	logic [GIW-1:0] grp_q;
	key_t           key_q;
	logic           take_left;
	logic           take_new;
	logic           take_right;

	always_comb begin
		// an empty slot sorts after everything
		gt = valid_q ? ({grp, ctrl.key} < {grp_q, key_q}) : 1'b1;
		// first entry of the addressed group
		head = valid_q && (grp_q == grp) && !(left_valid && (left_grp == grp));
		take_left = ctrl.ins && gt && left_gt;
		take_new = ctrl.ins && gt && !left_gt;
		take_right = ctrl.rem && valid_q && (grp_q >= grp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_left) begin
			valid_q <= left_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_right) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_left) begin
			grp_q <= left_grp;
			key_q <= left_key;
		end else if (take_new) begin
			grp_q <= grp;
			key_q <= ctrl.key;
		end else if (take_right) begin
			grp_q <= right_grp;
			key_q <= right_key;
		end
	end

	assign valid = valid_q;
	assign grp_out = grp_q;
	assign key = key_q;

endmodule

### hdl/gmpq_group_cell.sv
// ----------------------------------------------------------------------------
// gmpq_group_cell
// one group table slot: tag match and entry count of its group
// ----------------------------------------------------------------------------
module gmpq_group_cell import gmpq_pkg::*; #(
	parameter int IDX = 0,
	parameter int GIW = 6,
	parameter int GCW = 7,
	parameter int CW  = 9
) (
	input  logic               clk,
	input  grp_op_t            op,
	input  logic signed [31:0] tag_new,
	input  logic [GIW-1:0]     grp,
	input  logic [GCW-1:0]     gcount,
	input  logic signed [31:0] lookup_tag,
	output logic               match,
	output logic [CW-1:0]      count
);

	logic signed [31:0] tag_q;
	logic [CW-1:0]      count_q;
	logic               create_hit;
	logic               own;

	always_comb begin
		create_hit = op.create && (gcount == GCW'(IDX));
		own = (grp == GIW'(IDX));
		// slots at or above the group count hold no live group
		match = (GCW'(IDX) < gcount) && (tag_q == lookup_tag);
	end

	always_ff @(posedge clk) begin
		if (create_hit) begin
			tag_q <= tag_new;
			count_q <= CW'(1);
		end else if (own && op.inc) begin
			count_q <= count_q + CW'(1);
		end else if (own && op.dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	assign count = count_q;

endmodule

### hdl/grouped_min_priority_queue.sv
// flow: a request is registered at accept; in S_APPLY the entry chain shifts
//   and the removed id is or-reduced per chunk; S_FIN merges the chunks and
//   registers the result when the output is free, taking the next request
// reset: control, counts and all entry valid bits clear at once; the group
//   table and entry payloads are not cleared and no clearing pass runs
// ----------------------------------------------------------------------------
// grouped_min_priority_queue
// per-group min priority queues kept in one sorted chain of entry cells
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grouped_min_priority_queue import gmpq_pkg::*; #(
	parameter int MAX_GROUPS = 64,
	parameter int ENTRIES    = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	gmpq_req_if.sink   req,
	gmpq_rsp_if.source rsp
);

	localparam int GIW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int GCW = $clog2(MAX_GROUPS + 1);
	localparam int CW  = $clog2(ENTRIES + 1);
	localparam int NCH = (ENTRIES + CHUNK - 1) / CHUNK;

	state_t state_q, state_d;

	// group table
	logic [MAX_GROUPS-1:0] grp_match;
	logic [CW-1:0]         grp_cnt [MAX_GROUPS];
	logic [GCW-1:0]        gcount_q;
	grp_op_t               grp_op;

	// entry chain
	logic [ENTRIES-1:0] ent_valid;
	logic [GIW-1:0]     ent_grp [ENTRIES];
	key_t               ent_key [ENTRIES];
	logic [ENTRIES-1:0] ent_gt;
	logic [ENTRIES-1:0] ent_head;
	logic [ENTRIES-1:0] ent_valid_inc;
	logic [CW-1:0]      ent_count_q;
	ent_ctrl_t          ent_ctrl;

	// lookup at accept
	logic           in_fire;
	logic           out_free;
	logic           have;
	logic [GIW-1:0] gidx;
	logic [CW-1:0]  gcnt;
	logic           do_add;
	logic           do_rem;
	logic           create;
	logic [GIW-1:0] tgt;
	status_t        status;

	logic               do_add_s1;
	logic               do_rem_s1;
	logic               create_s1;
	logic [GIW-1:0]     grp_s1;
	key_t               key_s1;
	logic signed [31:0] tag_s1;
	status_t            status_s1;

	logic [31:0] part      [NCH];
	logic [31:0] part_s2   [NCH];
	logic        found_s2;
	status_t     status_s2;
	logic [31:0] rid_fin;

	logic        out_valid_q;
	logic        found_q;
	logic [31:0] rid_q;
	status_t     status_q;

	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) || ((state_q == S_FIN) && out_free);
	assign in_fire = req.valid && req.ready;

	// group cells
	for (genvar i = 0; i < MAX_GROUPS; i++) begin : g_grp
		gmpq_group_cell #(
			.IDX (i),
			.GIW (GIW),
			.GCW (GCW),
			.CW  (CW)
		) u_cell (
			.clk        (clk),
			.op         (grp_op),
			.tag_new    (tag_s1),
			.grp        (grp_s1),
			.gcount     (gcount_q),
			.lookup_tag (req.group_tag),
			.match      (grp_match[i]),
			.count      (grp_cnt[i])
		);
	end

	// entry cells, each wired to its neighbors
	for (genvar e = 0; e < ENTRIES; e++) begin : g_ent
		logic           l_valid;
		logic [GIW-1:0] l_grp;
		key_t           l_key;
		logic           l_gt;
		logic           r_valid;
		logic [GIW-1:0] r_grp;
		key_t           r_key;

		if (e == 0) begin : g_first
			assign l_valid = 1'b0;
			assign l_grp = '0;
			assign l_key = '0;
			assign l_gt = 1'b0;
		end else begin : g_mid_l
			assign l_valid = ent_valid[e-1];
			assign l_grp = ent_grp[e-1];
			assign l_key = ent_key[e-1];
			assign l_gt = ent_gt[e-1];
		end

		if (e == ENTRIES - 1) begin : g_last
			assign r_valid = 1'b0;
			assign r_grp = '0;
			assign r_key = '0;
		end else begin : g_mid_r
			assign r_valid = ent_valid[e+1];
			assign r_grp = ent_grp[e+1];
			assign r_key = ent_key[e+1];
		end

		gmpq_entry_cell #(
			.GIW (GIW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ent_ctrl),
			.grp         (grp_s1),
			.left_valid  (l_valid),
			.left_grp    (l_grp),
			.left_key    (l_key),
			.left_gt     (l_gt),
			.right_valid (r_valid),
			.right_grp   (r_grp),
			.right_key   (r_key),
			.valid       (ent_valid[e]),
			.grp_out     (ent_grp[e]),
			.key         (ent_key[e]),
			.gt          (ent_gt[e]),
			.head        (ent_head[e])
		);
	end

	// group lookup and request decode
	always_comb begin
		have = 1'b0;
		gidx = '0;
		gcnt = '0;
		for (int i = 0; i < MAX_GROUPS; i++) begin
			have = have | grp_match[i];
			gidx = gidx | (grp_match[i] ? GIW'(i) : '0);
			gcnt = gcnt | (grp_match[i] ? grp_cnt[i] : '0);
		end

		do_add = 1'b0;
		do_rem = 1'b0;
		create = 1'b0;
		tgt = gidx;
		status = STAT_OK;
		if (req.action == ACT_ADD) begin
			if (ent_count_q == CW'(ENTRIES)) begin
				status = STAT_STORE_FULL;
			end else if (!have && (gcount_q >= GCW'(MAX_GROUPS))) begin
				status = STAT_GTAB_FULL;
			end else begin
				do_add = 1'b1;
				create = !have;
				tgt = have ? gidx : gcount_q[GIW-1:0];
			end
		end else begin
			if (!have || (gcnt == '0)) begin
				status = STAT_ABSENT;
			end else begin
				do_rem = 1'b1;
			end
		end
	end

	always_comb begin
		ent_ctrl.ins = (state_q == S_APPLY) && do_add_s1;
		ent_ctrl.rem = (state_q == S_APPLY) && do_rem_s1;
		ent_ctrl.key = key_s1;
		grp_op.create = (state_q == S_APPLY) && do_add_s1 && create_s1;
		grp_op.inc = (state_q == S_APPLY) && do_add_s1 && !create_s1;
		grp_op.dec = (state_q == S_APPLY) && do_rem_s1;
	end

	// removed id: head cell's id, reduced in chunks
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			part[c] = '0;
			for (int k = 0; k < CHUNK; k++) begin
				if (c * CHUNK + k < ENTRIES) begin
					if (ent_head[c * CHUNK + k]) begin
						part[c] = part[c] | ent_key[c * CHUNK + k].id;
					end
				end
			end
		end
		rid_fin = '0;
		for (int c = 0; c < NCH; c++) begin
			rid_fin = rid_fin | part_s2[c];
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_free) begin
					state_d = in_fire ? S_APPLY : S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			do_add_s1 <= 1'b0;
			do_rem_s1 <= 1'b0;
			create_s1 <= 1'b0;
			gcount_q <= '0;
			ent_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				do_add_s1 <= do_add;
				do_rem_s1 <= do_rem;
				create_s1 <= create;
			end
			if (state_q == S_APPLY) begin
				if (do_add_s1) begin
					ent_count_q <= ent_count_q + CW'(1);
				end else if (do_rem_s1) begin
					ent_count_q <= ent_count_q - CW'(1);
				end
				if (do_add_s1 && create_s1) begin
					gcount_q <= gcount_q + GCW'(1);
				end
			end
			if ((state_q == S_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			grp_s1 <= tgt;
			key_s1.prio <= req.priority_req;
			key_s1.id <= req.item_id;
			tag_s1 <= req.group_tag;
			status_s1 <= status;
		end
		if (state_q == S_APPLY) begin
			found_s2 <= do_rem_s1;
			status_s2 <= status_s1;
			for (int c = 0; c < NCH; c++) begin
				part_s2[c] <= do_rem_s1 ? part[c] : '0;
			end
		end
		if ((state_q == S_FIN) && out_free) begin
			found_q <= found_s2;
			rid_q <= rid_fin;
			status_q <= status_s2;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.found = found_q;
	assign rsp.removed_id = rid_q;
	assign rsp.status = status_q;

	assign ent_valid_inc = ent_valid + ENTRIES'(1);

	`GMPQ_ASSERT_NEXT(a_accept_apply, clk, arst_n, req.valid && req.ready, state_q == S_APPLY)
	`GMPQ_ASSERT_IMPL(a_fill_count, clk, arst_n, 1'b1, $countones(ent_valid) == ent_count_q)
	`GMPQ_ASSERT_IMPL(a_chain_packed, clk, arst_n, 1'b1, (ent_valid & ent_valid_inc) == '0)
	`GMPQ_ASSERT_IMPL(a_found_ok, clk, arst_n, rsp.valid && rsp.found, rsp.status == STAT_OK)

endmodule

### tb/tb_grouped_min_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_grouped_min_priority_queue
// Self-checking bench for the grouped min priority queue. A driver sends add
// and remove requests from a queue of pending words and works out each
// expected response with its own model of the groups and the entry store. A
// monitor compares every response, field by field, with the oldest expected
// one. The run is a directed part and then four random phases. The phases
// fill the group table and the entry store, then remove from the store, under
// different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module tb_grouped_min_priority_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import gmpq_pkg::*;

	localparam int MAX_GROUPS = 64;
	localparam int ENTRIES    = 256;
	localparam int POOL_SIZE  = 80;

	typedef struct packed {
		logic        action;
		logic [31:0] group_tag;
		logic [31:0] item_id;
		logic [31:0] prio;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [31:0] removed_id;
		status_t     status;
	} response_t;

	logic clk;
	logic arst_n;

	gmpq_req_if req_if();
	gmpq_rsp_if rsp_if();

	grouped_min_priority_queue #(
		.MAX_GROUPS(MAX_GROUPS),
		.ENTRIES(ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	// queue model: group table and shared entry store
	logic [31:0] group_tags [MAX_GROUPS];
	int          group_total = 0;
	key_t        entry_key [ENTRIES];
	int          entry_group [ENTRIES];
	bit          entry_used [ENTRIES];

	request_t    pending_words[$];
	response_t   awaited_responses[$];
	request_t    word_on_bus;
	logic [31:0] tag_pool [POOL_SIZE];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int add_count      = 0;
	int remove_count   = 0;
	int status_count [4];

	function automatic int find_group(input logic [31:0] tag);
		int g;
		for (g = 0; g < group_total; g++) begin
			if (group_tags[g] == tag)
				return g;
		end
		return -1;
	endfunction

	function automatic response_t serve_request(input request_t r);
		response_t res;
		int grp;
		int slot;
		int best;
		res.found      = 1'b0;
		res.removed_id = '0;
		res.status     = STAT_OK;
		grp = find_group(r.group_tag);
		if (r.action == ACT_ADD) begin
			slot = -1;
			for (int e = 0; e < ENTRIES; e++) begin
				if (!entry_used[e] && slot < 0)
					slot = e;
			end
			// store full wins over a full group table
			if (slot < 0) begin
				res.status = STAT_STORE_FULL;
			end else if (grp < 0 && group_total >= MAX_GROUPS) begin
				res.status = STAT_GTAB_FULL;
			end else begin
				if (grp < 0) begin
					grp = group_total;
					group_tags[grp] = r.group_tag;
					group_total++;
				end
				entry_key[slot]   = {r.prio, r.item_id};
				entry_group[slot] = grp;
				entry_used[slot]  = 1'b1;
			end
		end else if (grp < 0) begin
			res.status = STAT_ABSENT;
		end else begin
			best = -1;
			for (int e = 0; e < ENTRIES; e++) begin
				if (entry_used[e] && entry_group[e] == grp &&
						(best < 0 || entry_key[e] < entry_key[best]))
					best = e;
			end
			if (best < 0) begin
				res.status = STAT_ABSENT;
			end else begin
				entry_used[best] = 1'b0;
				res.found        = 1'b1;
				res.removed_id   = entry_key[best].id;
			end
		end
		return res;
	endfunction

	task automatic push_word(input logic act, input logic [31:0] tag, input logic [31:0] id,
			input logic [31:0] prio);
		request_t r;
		r.action    = act;
		r.group_tag = tag;
		r.item_id   = id;
		r.prio      = prio;
		pending_words.push_back(r);
	endtask

	// id and priority: many small values so that ties are common, some extremes
	task automatic push_random_word(input logic act, input logic [31:0] tag);
		logic [31:0] id;
		logic [31:0] prio;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			id = $urandom_range(0, 7);
		else if (pick < 50)
			id = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		else
			id = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 40)
			prio = $urandom_range(0, 15);
		else if (pick < 50)
			prio = $urandom_range(0, 1) ? 32'hffff_ffff : 32'h0;
		else
			prio = $urandom;
		push_word(act, tag, id, prio);
	endtask

	// seq_count adds to fresh pool tags first, then random words over the pool
	task automatic queue_phase(input int seq_from, input int seq_count, input int rand_count,
			input int add_pct, input int pool_top);
		logic [31:0] tag;
		logic act;
		for (int k = 0; k < seq_count; k++)
			push_random_word(ACT_ADD, tag_pool[seq_from + k]);
		for (int k = 0; k < rand_count; k++) begin
			act = ($urandom_range(0, 99) < add_pct) ? ACT_ADD : ACT_REMOVE;
			if ($urandom_range(0, 99) < 5)
				tag = $urandom;
			else
				tag = tag_pool[$urandom_range(0, pool_top - 1)];
			push_random_word(act, tag);
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || awaited_responses.size() != 0 || req_if.valid)
			@(posedge clk);
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.action  = ACT_ADD;
		req_if.group_tag    = '0;
		req_if.item_id      = '0;
		req_if.priority_req = '0;
		rsp_if.ready   = 1'b0;
		fork
			forever #6ns clk = ~clk;
		join_none
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#5ms;
		$display("timeout at %0t", $time);
		$display("simulation failed");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_if.valid <= 1'b0;
		end else begin
			if (req_if.valid && req_if.ready) begin
				awaited_responses.push_back(serve_request(word_on_bus));
				if (word_on_bus.action == ACT_ADD)
					add_count++;
				else
					remove_count++;
			end
			if (!req_if.valid || req_if.ready) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					word_on_bus = pending_words.pop_front();
					req_if.valid        <= 1'b1;
					req_if.action       <= word_on_bus.action;
					req_if.group_tag    <= word_on_bus.group_tag;
					req_if.item_id      <= word_on_bus.item_id;
					req_if.priority_req <= word_on_bus.prio;
				end else begin
					req_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (awaited_responses.size() == 0) begin
					$display("%0t: response with none expected: found %0b id %h status %0d",
						$time, rsp_if.found, rsp_if.removed_id, rsp_if.status);
					error_count++;
				end else begin
					response_t exp;
					exp = awaited_responses.pop_front();
					status_count[exp.status]++;
					if (rsp_if.found !== exp.found) begin
						$display("%0t: found mismatch: expected %0b actual %0b",
							$time, exp.found, rsp_if.found);
						error_count++;
					end
					if (rsp_if.removed_id !== exp.removed_id) begin
						$display("%0t: removed_id mismatch: expected %h actual %h",
							$time, exp.removed_id, rsp_if.removed_id);
						error_count++;
					end
					if (rsp_if.status !== exp.status) begin
						$display("%0t: status mismatch: expected %0d actual %0d",
							$time, exp.status, rsp_if.status);
						error_count++;
					end
				end
			end
			rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	initial begin
		for (int k = 0; k < POOL_SIZE; k++)
			tag_pool[k] = $urandom;
		@(posedge arst_n);

		// directed: extreme tags, ids and priorities, ties, empty and unknown groups
		push_word(ACT_REMOVE, 32'h0, 32'h1234, 32'h1);
		push_word(ACT_ADD, 32'h8000_0000, 32'h0, 32'hffff_ffff);
		push_word(ACT_ADD, 32'h8000_0000, 32'hffff_ffff, 32'h0);
		push_word(ACT_ADD, 32'h8000_0000, 32'h5, 32'h0);
		push_word(ACT_ADD, 32'h8000_0000, 32'h5, 32'h0);
		push_word(ACT_REMOVE, 32'h8000_0000, 32'h0, 32'h0);
		push_word(ACT_REMOVE, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
		push_word(ACT_REMOVE, 32'h8000_0000, 32'h0, 32'h0);
		push_word(ACT_REMOVE, 32'h8000_0000, 32'h0, 32'h0);
		push_word(ACT_REMOVE, 32'h8000_0000, 32'h0, 32'h0);
		push_word(ACT_ADD, 32'h7fff_ffff, 32'h1, 32'h7);
		push_word(ACT_ADD, 32'hffff_ffff, 32'h2, 32'h7);
		push_word(ACT_ADD, 32'h0, 32'h3, 32'h7);
		push_word(ACT_REMOVE, 32'h7fff_ffff, 32'h0, 32'h0);
		push_word(ACT_REMOVE, 32'hffff_ffff, 32'hdead_beef, 32'h1);
		push_word(ACT_REMOVE, 32'h0, 32'h0, 32'h0);
		push_word(ACT_REMOVE, 32'h0001_2345, 32'h0, 32'h0);
		push_word(ACT_ADD, 32'h0, 32'haaaa_aaaa, 32'h5555_5555);
		push_word(ACT_ADD, 32'h0, 32'h5555_5555, 32'haaaa_aaaa);
		push_word(ACT_REMOVE, 32'h0, 32'h0, 32'h0);
		wait_drained();

		// no idling: create the first pool groups, mixed traffic
		queue_phase(0, 40, 140, 65, 40);
		wait_drained();

		// sender idles: the group table fills, later new tags are refused
		send_idle_pct = 50;
		queue_phase(40, 40, 130, 75, POOL_SIZE);
		wait_drained();

		// receiver stalls: adds only, enough to fill the entry store
		send_idle_pct  = 0;
		recv_stall_pct = 50;
		queue_phase(0, 0, 260, 100, 40);
		wait_drained();

		// both idle a little: mostly removes, draining groups
		send_idle_pct  = 11;
		recv_stall_pct = 11;
		queue_phase(0, 0, 150, 10, POOL_SIZE);
		wait_drained();

		repeat (10) @(posedge clk);
		$display("%0d adds and %0d removes over %0d groups", add_count, remove_count,
			group_total);
		$display("responses: %0d ok, %0d absent, %0d store full, %0d table full, %0d errors",
			status_count[STAT_OK], status_count[STAT_ABSENT], status_count[STAT_STORE_FULL],
			status_count[STAT_GTAB_FULL], error_count);
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hdl
hdl/gmpq_pkg.sv
hdl/gmpq_req_if.sv
hdl/gmpq_rsp_if.sv
hdl/gmpq_entry_cell.sv
hdl/gmpq_group_cell.sv
hdl/grouped_min_priority_queue.sv
tb/tb_grouped_min_priority_queue.sv
